FILE: src/thb_pkg.sv
// Shared types and constants for the traffic history buckets block.
// No dependencies; every other file imports this package.
package thb_pkg;

   localparam int unsigned KEY_W = 32;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned TOT_W = 64;
   localparam int unsigned IDX_W = 6;
   localparam logic [CNT_W-1:0] ROLLOVER_RESET = 32'd235929600;

   typedef enum logic [1:0] {
      OP_SAMPLE     = 2'd0,
      OP_READ_DAY   = 2'd1,
      OP_READ_MONTH = 2'd2,
      OP_REPRIME    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RM_UPDATE = 2'd0,
      RM_TAIL   = 2'd1,
      RM_INDEX  = 2'd2
   } ring_mode_type;

   typedef enum logic [1:0] {
      RS_IDLE  = 2'd0,
      RS_SCAN  = 2'd1,
      RS_APPLY = 2'd2
   } ring_state_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TOT_W-1:0] rx;
      logic [TOT_W-1:0] tx;
   } entry_type;

   typedef struct packed {
      ring_mode_type    mode;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] drx;
      logic [CNT_W-1:0] dtx;
      logic [IDX_W-1:0] idx;
   } ring_cmd_type;

endpackage

FILE: src/thb_cell.sv
// One history entry cell: key and two totals, loaded from its neighbor
// on every shift. Depends on thb_pkg.
module thb_cell
   import thb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type d,
   output entry_type q
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift ? d : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule

FILE: src/thb_ring.sv
// History ring built as a circulating chain of entry cells with a
// scan pass (key match) and an apply pass (update or read at the head).
// Depends on thb_pkg and thb_cell.
module thb_ring
   import thb_pkg::*;
#(
   parameter int unsigned DEPTH = 62
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ring_cmd_type cmd,
   output logic         busy,
   output entry_type    result
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

   ring_state_type state_ff, state_in;
   ring_cmd_type   cmd_ff, cmd_in;
   logic [IW-1:0]  cnt_ff, cnt_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [IW-1:0]  hit_idx_ff, hit_idx_in;
   logic           hit_ff, hit_in;
   logic           tail_hit_ff, tail_hit_in;
   logic           fresh_ff, fresh_in;
   logic [IDX_W-1:0] target_ff, target_in;
   entry_type      result_ff, result_in;

   entry_type q [DEPTH];
   entry_type d [DEPTH];
   entry_type head_next;
   entry_type modified;
   logic      at_target;
   logic      shift;
   logic      key_eq;

   assign shift = (state_ff != RS_IDLE);
   assign key_eq = (q[0].key == cmd_ff.key);
   assign at_target = (IDX_W'(cnt_ff) == target_ff);

   always_comb begin
      modified = q[0];
      if (cmd_ff.mode == RM_UPDATE) begin
         if (fresh_ff) begin
            modified.key = cmd_ff.key;
            modified.rx  = '0;
            modified.tx  = '0;
         end
         modified.rx = modified.rx + TOT_W'(cmd_ff.drx);
         modified.tx = modified.tx + TOT_W'(cmd_ff.dtx);
      end
   end

   always_comb begin
      head_next = q[0];
      if (state_ff == RS_APPLY && at_target) begin
         head_next = modified;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_wrap
         assign d[i] = head_next;
      end else begin : g_link
         assign d[i] = q[i+1];
      end
      thb_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (d[i]),
         .q     (q[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      tail_in     = tail_ff;
      hit_idx_in  = hit_idx_ff;
      hit_in      = hit_ff;
      tail_hit_in = tail_hit_ff;
      fresh_in    = fresh_ff;
      target_in   = target_ff;
      result_in   = result_ff;
      unique case (state_ff)
         RS_IDLE: begin
            if (start) begin
               cmd_in      = cmd;
               cnt_in      = '0;
               hit_in      = 1'b0;
               tail_hit_in = 1'b0;
               fresh_in    = 1'b0;
               result_in   = '0;
               if (cmd.mode == RM_UPDATE) begin
                  state_in = RS_SCAN;
               end else begin
                  state_in  = RS_APPLY;
                  target_in = (cmd.mode == RM_INDEX) ? cmd.idx : IDX_W'(tail_ff);
               end
            end
         end
         RS_SCAN: begin
            if (key_eq) begin
               hit_in     = 1'b1;
               hit_idx_in = cnt_ff;
               if (cnt_ff == tail_ff) begin
                  tail_hit_in = 1'b1;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = RS_APPLY;
               if (tail_hit_in) begin
                  target_in = IDX_W'(tail_ff);
               end else if (hit_in) begin
                  target_in = IDX_W'(hit_idx_in);
               end else begin
                  // No entry holds the key: open a new one after the tail.
                  tail_in   = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
                  target_in = IDX_W'(tail_in);
                  fresh_in  = 1'b1;
               end
            end
         end
         RS_APPLY: begin
            if (at_target) begin
               result_in = modified;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = RS_IDLE;
            end
         end
         default: state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= RS_IDLE;
         cnt_ff      <= '0;
         tail_ff     <= '0;
         hit_ff      <= 1'b0;
         tail_hit_ff <= 1'b0;
         fresh_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         tail_ff     <= tail_in;
         hit_ff      <= hit_in;
         tail_hit_ff <= tail_hit_in;
         fresh_ff    <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      hit_idx_ff <= hit_idx_in;
      target_ff  <= target_in;
      result_ff  <= result_in;
   end

   assign busy   = shift;
   assign result = result_ff;

   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= LAST) else $error("ring tail out of range");
   a_apply_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RS_APPLY && cnt_ff == LAST) |=> state_ff == RS_IDLE)
      else $error("apply pass did not end");
   a_tail_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff != RS_SCAN) |=> $stable(tail_ff) || $past(reset))
      else $error("tail moved outside the scan pass");

endmodule

FILE: src/traffic_history_buckets.sv
// Traffic history buckets: counter deltas with a rollover guard, summed
// into daily and monthly rings of circulating entry cells.
// A sample with valid time runs a scan pass then an apply pass in each ring,
// other requests only the apply pass; the deeper ring sets when it ends.
// One request at a time; busy drops in the strobe cycle, so the next request
// can be accepted in that cycle. The receiver cannot stall. Synchronous reset clears
// entries, tails and priming, and reloads the limit with its default.
module traffic_history_buckets
   import thb_pkg::*;
#(
   parameter int unsigned DAILY_DEPTH   = 62,
   parameter int unsigned MONTHLY_DEPTH = 25
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [CNT_W-1:0]   req_rx_count,
   input  logic [CNT_W-1:0]   req_tx_count,
   input  logic               req_time_valid,
   input  logic [KEY_W-1:0]   req_day_key,
   input  logic [KEY_W-1:0]   req_month_key,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic               csr_write_enable,
   input  logic [CNT_W-1:0]   csr_write_data,
   output logic               rsp_strobe,
   output logic [CNT_W-1:0]   rsp_rx_delta,
   output logic [CNT_W-1:0]   rsp_tx_delta,
   output logic [KEY_W-1:0]   rsp_day_entry_key,
   output logic [TOT_W-1:0]   rsp_day_rx_total,
   output logic [TOT_W-1:0]   rsp_day_tx_total,
   output logic [KEY_W-1:0]   rsp_month_entry_key,
   output logic [TOT_W-1:0]   rsp_month_rx_total,
   output logic [TOT_W-1:0]   rsp_month_tx_total
);

   state_type        state_ff, state_in;
   opcode_type       op_ff;
   opcode_type       op;
   logic             primed_ff;
   logic [CNT_W-1:0] last_rx_ff, last_tx_ff;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] drx_ff, dtx_ff;
   logic [CNT_W-1:0] drx, dtx;
   logic [CNT_W-1:0] raw_rx, raw_tx;
   logic             strobe_ff;
   entry_type        day_out_ff, month_out_ff;
   ring_cmd_type     day_cmd, month_cmd;
   entry_type        day_result, month_result;
   logic             day_busy, month_busy;
   logic             accept;
   logic             finish;

   assign op     = opcode_type'(req_opcode);
   assign accept = start && (state_ff == ST_IDLE);

   // A backwards step whose wrapped delta is larger than the limit is a counter reset, not a wrap.
   assign raw_rx = req_rx_count - last_rx_ff;
   assign raw_tx = req_tx_count - last_tx_ff;
   always_comb begin
      drx = '0;
      dtx = '0;
      if (primed_ff) begin
         drx = (req_rx_count < last_rx_ff && raw_rx > limit_ff) ? '0 : raw_rx;
         dtx = (req_tx_count < last_tx_ff && raw_tx > limit_ff) ? '0 : raw_tx;
      end
   end

   // Both rings run together; each either updates by key, shows its tail,
   // or reads one entry by index.
   always_comb begin
      day_cmd.key    = req_day_key;
      day_cmd.drx    = drx;
      day_cmd.dtx    = dtx;
      day_cmd.idx    = req_entry_index;
      day_cmd.mode   = RM_TAIL;
      month_cmd      = day_cmd;
      month_cmd.key  = req_month_key;
      case (op)
         OP_SAMPLE: begin
            if (req_time_valid) begin
               day_cmd.mode   = RM_UPDATE;
               month_cmd.mode = RM_UPDATE;
            end
         end
         OP_READ_DAY:   day_cmd.mode   = RM_INDEX;
         OP_READ_MONTH: month_cmd.mode = RM_INDEX;
         default: ;
      endcase
   end

   thb_ring #(.DEPTH(DAILY_DEPTH)) u_day_ring (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cmd    (day_cmd),
      .busy   (day_busy),
      .result (day_result)
   );

   thb_ring #(.DEPTH(MONTHLY_DEPTH)) u_month_ring (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .cmd    (month_cmd),
      .busy   (month_busy),
      .result (month_result)
   );

   assign finish = (state_ff == ST_RUN) && !day_busy && !month_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         primed_ff  <= 1'b0;
         last_rx_ff <= '0;
         last_tx_ff <= '0;
         limit_ff   <= ROLLOVER_RESET;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= finish;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (accept && (op == OP_SAMPLE || op == OP_REPRIME)) begin
            primed_ff  <= 1'b1;
            last_rx_ff <= req_rx_count;
            last_tx_ff <= req_tx_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op;
         drx_ff <= (op == OP_SAMPLE) ? drx : '0;
         dtx_ff <= (op == OP_SAMPLE) ? dtx : '0;
      end
      if (finish) begin
         // The ring not addressed by a read shows zeros.
         day_out_ff   <= (op_ff == OP_READ_MONTH) ? '0 : day_result;
         month_out_ff <= (op_ff == OP_READ_DAY) ? '0 : month_result;
      end
   end

   assign busy                = (state_ff == ST_RUN);
   assign rsp_strobe          = strobe_ff;
   assign rsp_rx_delta        = drx_ff;
   assign rsp_tx_delta        = dtx_ff;
   assign rsp_day_entry_key   = day_out_ff.key;
   assign rsp_day_rx_total    = day_out_ff.rx;
   assign rsp_day_tx_total    = day_out_ff.tx;
   assign rsp_month_entry_key = month_out_ff.key;
   assign rsp_month_rx_total  = month_out_ff.rx;
   assign rsp_month_tx_total  = month_out_ff.tx;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");
   a_strobe_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result without request");
   a_read_no_delta: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && op_ff != OP_SAMPLE) |-> (rsp_rx_delta == '0 && rsp_tx_delta == '0))
      else $error("delta on non-sample request");

endmodule
